// File: rtl/rmr_pkg.sv
// Shared widths, codes, reset values and types of the frame descriptor ring.
package rmr_pkg;

  localparam int READER_SLOTS_DEF = 8;
  localparam int RING_DEPTH_DEF   = 64;
  localparam int META_BITS_DEF    = 64;
  localparam int LENGTH_BITS_DEF  = 24;

  localparam int FUNC_W     = 3;
  localparam int READER_W   = 3;
  localparam int META_W     = 64;
  localparam int LEN_W      = 24;
  localparam int STATUS_W   = 2;
  localparam int PEND_W     = 6;
  localparam int SLOT_W     = 3;
  localparam int COUNT_W    = 3;
  localparam int FSLOT_W    = 7;
  localparam int DBYTES_W   = 25;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 25;

  localparam logic [FUNC_W-1:0] FUNC_PUT     = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PEEK    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_SYNC    = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_ATTACH  = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_DETACH  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REFUSED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SLOT   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SLOTS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BYTES  = 1'd1;

  localparam logic [FSLOT_W-1:0]  FRAME_SLOTS_RST = 7'd64;
  localparam logic [DBYTES_W-1:0] DATA_BYTES_RST  = 25'd16777216;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

endpackage

// File: rtl/rmr_if.sv
// Request and response channel interfaces of the frame descriptor ring.
interface rmr_in_if;
  import rmr_pkg::*;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [READER_W-1:0] reader;
  logic [META_W-1:0]   meta;
  logic [LEN_W-1:0]    length;
  modport source(output valid, func, reader, meta, length, input ready);
  modport sink(input valid, func, reader, meta, length, output ready);
endinterface

interface rmr_out_if;
  import rmr_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [META_W-1:0]   meta_out;
  logic [LEN_W-1:0]    length_out;
  logic [LEN_W-1:0]    offset_out;
  logic [PEND_W-1:0]   pending;
  logic [SLOT_W-1:0]   slot_out;
  logic [COUNT_W-1:0]  reader_count;
  modport source(output valid, status, meta_out, length_out, offset_out, pending, slot_out,
                 reader_count, input ready);
  modport sink(input valid, status, meta_out, length_out, offset_out, pending, slot_out,
               reader_count, output ready);
endinterface

// File: rtl/rmr_mod.sv
// Restoring remainder unit: one quotient bit per cycle.
module rmr_mod #(
  parameter int VAL_W = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [VAL_W-1:0]   value,
  input  logic [VAL_W:0]     divisor,
  output rmr_pkg::mod_stat_t stat,
  output logic [VAL_W-1:0]   result
);
  import rmr_pkg::*;

  localparam int CNT_W = $clog2(VAL_W + 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [VAL_W-1:0] shreg;
  logic [VAL_W-1:0] rem;
  logic [VAL_W:0]   dvs;
  logic [VAL_W:0]   trial;
  logic [VAL_W-1:0] rem_next;
  mod_stat_t        stat_w;

  assign trial    = {rem, shreg[VAL_W-1]};
  assign rem_next = (trial >= dvs) ? VAL_W'(trial - dvs) : trial[VAL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      shreg <= value;
      rem   <= '0;
      dvs   <= divisor;
      cnt   <= CNT_W'(VAL_W);
    end else if (busy) begin
      shreg <= shreg << 1;
      rem   <= rem_next;
      cnt   <= cnt - CNT_W'(1);
    end
  end

  assign stat_w.busy = busy;
  assign stat_w.done = done;
  assign stat        = stat_w;
  assign result      = rem;

endmodule

// File: rtl/rmr_desc_store.sv
// Descriptor store: metadata, length and offset per ring slot, registered read.
module rmr_desc_store #(
  parameter int IDX_W     = 6,
  parameter int META_BITS = 64
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [IDX_W-1:0]            waddr,
  input  logic [META_BITS-1:0]        wmeta,
  input  logic [rmr_pkg::LEN_W-1:0]   wlen,
  input  logic [rmr_pkg::LEN_W-1:0]   woff,
  input  logic                        re,
  input  logic [IDX_W-1:0]            raddr,
  output logic [META_BITS-1:0]        rmeta,
  output logic [rmr_pkg::LEN_W-1:0]   rlen,
  output logic [rmr_pkg::LEN_W-1:0]   roff
);
  import rmr_pkg::*;

  localparam int WORD_W = META_BITS + 2 * LEN_W;
  localparam int DEPTH  = 1 << IDX_W;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wmeta, wlen, woff};
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  assign rmeta = rdata[WORD_W-1 -: META_BITS];
  assign rlen  = rdata[2*LEN_W-1 -: LEN_W];
  assign roff  = rdata[LEN_W-1:0];

endmodule

// File: rtl/multi_reader_frame_ring_unit.sv
// Top level of the frame descriptor ring: control, reader tail store and status.
//
// One writer and up to READER_SLOTS-1 readers share a ring of frame descriptors.
// Each request word on req carries func, reader, meta and length; each one yields
// exactly one response word on rsp (status, descriptor fields, pending count,
// granted slot, attached reader count), in request order.
// Channels: valid/ready; a word moves at a rising edge with both high.
// Configuration: cfg_we with cfg_index 0 (frame_slots) or 1 (data_bytes); write
// only while no request is in flight.
// Throughput: one request at a time. Put, advance, sync, attach and detach go
// through accept and the tail store read; peek then also reads the descriptor
// store after the tail read. If frame_slots was lowered below a stored head or
// tail index, each such index first goes through the remainder unit.
// Response register: a finished word waits in the rsp register; while rsp stalls
// the block holds the next request before its commit, so nothing is lost.
// Reset: head, write offset, tails, slot flags and reader count clear at once
// (tails carry valid bits, no clearing pass); frame_slots resets to 64 and
// data_bytes to 2^24; req.ready stays low while rst is high. Descriptor
// contents are undefined until written.
module multi_reader_frame_ring_unit #(
  parameter int READER_SLOTS = rmr_pkg::READER_SLOTS_DEF,
  parameter int RING_DEPTH   = rmr_pkg::RING_DEPTH_DEF,
  parameter int META_BITS    = rmr_pkg::META_BITS_DEF,
  parameter int LENGTH_BITS  = rmr_pkg::LENGTH_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  rmr_in_if.sink                          req,
  rmr_out_if.source                       rsp,
  input  logic                            cfg_we,
  input  logic [rmr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rmr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rmr_pkg::*;

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int NW    = IDX_W + 1;
  localparam int TW    = $clog2(READER_SLOTS);
  localparam int CW    = TW;
  localparam int SUM_W = DBYTES_W + 1;

  // Keep only the low LENGTH_BITS of a length; wrap offsets that exceed them.
  localparam logic [LEN_W-1:0] LEN_MASK = (LENGTH_BITS >= LEN_W) ? {LEN_W{1'b1}}
                                          : LEN_W'((64'd1 << LENGTH_BITS) - 64'd1);
  localparam logic [DBYTES_W-1:0] OFF_MAX = (LENGTH_BITS >= DBYTES_W) ? {DBYTES_W{1'b1}}
                                            : DBYTES_W'((64'd1 << LENGTH_BITS) - 64'd1);

  localparam logic [1:0] S_IDLE = 2'd0;  // ready for a request
  localparam logic [1:0] S_TAIL = 2'd1;  // tail read data back, fast commit
  localparam logic [1:0] S_RED  = 2'd2;  // bring head or tail below the slot count
  localparam logic [1:0] S_DESC = 2'd3;  // peek descriptor read data back

  // Control and configuration state.
  logic [1:0]              state;
  logic [FSLOT_W-1:0]      frame_slots;
  logic [DBYTES_W-1:0]     data_bytes;
  logic [IDX_W-1:0]        head_index;
  logic [DBYTES_W-1:0]     write_offset;
  logic [CW-1:0]           attached_count;
  logic [READER_SLOTS-1:0] slot_taken;
  logic [READER_SLOTS-1:0] tail_valid;
  logic                    out_valid;

  // Tail store: one entry per reader slot, read at the request's reader.
  logic [IDX_W-1:0] tail_mem [READER_SLOTS];
  logic [IDX_W-1:0] tail_q;
  logic             tvalid_q;

  // Request held for the length of the operation.
  logic [FUNC_W-1:0]    func_q;
  logic                 rd_valid_q;
  logic [TW-1:0]        rd_addr_q;
  logic [META_BITS-1:0] meta_q;
  logic [LEN_W-1:0]     len_q;
  logic [IDX_W-1:0]     h_q;
  logic [IDX_W-1:0]     t_q;
  logic                 mod_sel;
  logic [PEND_W-1:0]    pend_q;

  // Response register payload.
  logic [STATUS_W-1:0] o_status;
  logic [META_W-1:0]   o_meta;
  logic [LEN_W-1:0]    o_len;
  logic [LEN_W-1:0]    o_off;
  logic [PEND_W-1:0]   o_pend;
  logic [SLOT_W-1:0]   o_slot;
  logic [COUNT_W-1:0]  o_count;

  logic accept;
  logic out_free;
  logic out_set;
  logic [31:0]   n_int;
  logic [NW-1:0] n;
  logic [IDX_W-1:0] t_raw;
  logic [IDX_W-1:0] cur_h;
  logic [IDX_W-1:0] cur_t;
  logic need_red;
  logic red_clear;
  logic fin;
  logic commit;

  mod_stat_t        mod_stat;
  logic             mod_start;
  logic             mod_pick_tail;
  logic [IDX_W-1:0] mod_value;
  logic [IDX_W-1:0] mod_result;

  logic [META_BITS-1:0] d_meta;
  logic [LEN_W-1:0]     d_len;
  logic [LEN_W-1:0]     d_off;

  // Operation results.
  logic [NW-1:0]       h_plus;
  logic [NW-1:0]       t_plus;
  logic [IDX_W-1:0]    h_inc;
  logic [IDX_W-1:0]    t_inc;
  logic                empty;
  logic                too_large;
  logic [SUM_W-1:0]    off_sum;
  logic [DBYTES_W-1:0] off_sel;
  logic                found;
  logic [TW-1:0]       free_idx;
  logic [NW-1:0]       diff;

  logic [STATUS_W-1:0] c_status;
  logic [META_W-1:0]   c_meta;
  logic [LEN_W-1:0]    c_len;
  logic [LEN_W-1:0]    c_off;
  logic [TW-1:0]       c_slot;
  logic [IDX_W-1:0]    c_head_after;
  logic [IDX_W-1:0]    c_tail_after;
  logic                c_tail_we;
  logic [TW-1:0]       c_tail_waddr;
  logic [IDX_W-1:0]    c_tail_wdata;
  logic                c_put_ok;
  logic                c_peek_hit;
  logic                c_set;
  logic                c_clr;
  logic                c_no_pend;
  logic [CW-1:0]       c_count;
  logic [DBYTES_W-1:0] c_woff;
  logic [PEND_W-1:0]   c_pend;

  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && !rst;

  // Effective slot count: frame_slots clamped to [2, RING_DEPTH].
  always_comb begin
    if (frame_slots < FSLOT_W'(2)) begin
      n_int = 32'd2;
    end else if (32'(frame_slots) > 32'(RING_DEPTH)) begin
      n_int = 32'(RING_DEPTH);
    end else begin
      n_int = 32'(frame_slots);
    end
  end
  assign n = NW'(n_int);

  // An entry never written reads as tail zero.
  assign t_raw = tvalid_q ? tail_q : '0;
  assign cur_h = h_q;
  assign cur_t = (state == S_TAIL) ? t_raw : t_q;

  assign need_red  = (NW'(h_q) >= n) || (rd_valid_q && (NW'(t_raw) >= n));
  assign red_clear = !mod_stat.busy && !mod_stat.done && (NW'(h_q) < n)
                     && (!rd_valid_q || (NW'(t_q) < n));
  assign fin       = ((state == S_TAIL) && !need_red) || ((state == S_RED) && red_clear);
  assign commit    = fin && (c_peek_hit || out_free);

  // Load the response register at a plain commit, or once the peeked descriptor is back.
  assign out_set = (commit && !c_peek_hit) || ((state == S_DESC) && out_free);

  assign mod_start     = (state == S_RED) && !mod_stat.busy && !mod_stat.done && !red_clear;
  assign mod_pick_tail = (NW'(h_q) < n);
  assign mod_value     = mod_pick_tail ? t_q : h_q;

  rmr_mod #(
    .VAL_W(IDX_W)
  ) u_mod (
    .clk    (clk),
    .rst    (rst),
    .start  (mod_start),
    .value  (mod_value),
    .divisor(n),
    .stat   (mod_stat),
    .result (mod_result)
  );

  rmr_desc_store #(
    .IDX_W    (IDX_W),
    .META_BITS(META_BITS)
  ) u_desc (
    .clk  (clk),
    .we   (commit && c_put_ok),
    .waddr(cur_h),
    .wmeta(meta_q),
    .wlen (len_q),
    .woff (c_off),
    .re   (commit && c_peek_hit),
    .raddr(cur_t),
    .rmeta(d_meta),
    .rlen (d_len),
    .roff (d_off)
  );

  // Ring arithmetic on indexes already below the slot count.
  assign h_plus = NW'(cur_h) + NW'(1);
  assign t_plus = NW'(cur_t) + NW'(1);
  assign h_inc  = (h_plus == n) ? '0 : h_plus[IDX_W-1:0];
  assign t_inc  = (t_plus == n) ? '0 : t_plus[IDX_W-1:0];
  assign empty  = (cur_t == cur_h);

  // Put: refuse over-long frames; wrap the offset when the frame would not fit.
  assign too_large = ({1'b0, len_q} > data_bytes);
  assign off_sum   = SUM_W'(write_offset) + SUM_W'(len_q);
  assign off_sel   = ((off_sum > SUM_W'(data_bytes)) || (write_offset > OFF_MAX))
                     ? '0 : write_offset;

  // Lowest free reader slot, writer slot excluded.
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = READER_SLOTS - 1; i >= 1; i--) begin
      if (!slot_taken[i]) begin
        found    = 1'b1;
        free_idx = TW'(i);
      end
    end
  end

  always_comb begin
    c_status     = ST_REFUSED;
    c_meta       = '0;
    c_len        = '0;
    c_off        = LEN_W'(off_sel);
    c_slot       = '0;
    c_head_after = cur_h;
    c_tail_after = cur_t;
    c_tail_we    = 1'b0;
    c_tail_waddr = rd_addr_q;
    c_tail_wdata = cur_h;
    c_put_ok     = 1'b0;
    c_peek_hit   = 1'b0;
    c_set        = 1'b0;
    c_clr        = 1'b0;
    c_no_pend    = !rd_valid_q;
    c_count      = attached_count;
    c_woff       = DBYTES_W'(off_sum - SUM_W'(write_offset) + SUM_W'(off_sel));
    case (func_q)
      FUNC_PUT: begin
        if (attached_count == '0) begin
          c_status = ST_REFUSED;
        end else if (too_large) begin
          c_status = ST_TOO_LARGE;
        end else begin
          c_put_ok     = 1'b1;
          c_head_after = h_inc;
          c_status     = ST_OK;
          c_meta       = META_W'(meta_q);
          c_len        = len_q;
        end
      end
      FUNC_PEEK: begin
        if (rd_valid_q && !empty) begin
          c_peek_hit = 1'b1;
          c_status   = ST_OK;
        end
      end
      FUNC_ADVANCE: begin
        if (rd_valid_q && !empty) begin
          c_tail_we    = 1'b1;
          c_tail_wdata = t_inc;
          c_tail_after = t_inc;
          c_status     = ST_OK;
        end
      end
      FUNC_SYNC: begin
        if (rd_valid_q) begin
          c_tail_we    = 1'b1;
          c_tail_after = cur_h;
          c_status     = ST_OK;
        end
      end
      FUNC_ATTACH: begin
        c_status  = ST_NO_SLOT;
        c_no_pend = 1'b1;
        if (found) begin
          c_set        = 1'b1;
          c_tail_we    = 1'b1;
          c_tail_waddr = free_idx;
          c_count      = attached_count + CW'(1);
          c_slot       = free_idx;
          c_status     = ST_OK;
        end
      end
      FUNC_DETACH: begin
        if (rd_valid_q && slot_taken[rd_addr_q]) begin
          c_clr    = 1'b1;
          c_count  = (attached_count != '0) ? attached_count - CW'(1) : attached_count;
          c_status = ST_OK;
        end
      end
      default: begin
        c_status = ST_REFUSED;
      end
    endcase
  end

  // Frames between the reader's tail and the head after the operation.
  assign diff   = (c_head_after >= c_tail_after)
                  ? NW'(c_head_after) - NW'(c_tail_after)
                  : NW'(c_head_after) + n - NW'(c_tail_after);
  assign c_pend = c_no_pend ? '0 : PEND_W'(diff);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      frame_slots    <= FRAME_SLOTS_RST;
      data_bytes     <= DATA_BYTES_RST;
      head_index     <= '0;
      write_offset   <= '0;
      attached_count <= '0;
      slot_taken     <= '0;
      tail_valid     <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_SLOTS: frame_slots <= cfg_data[FSLOT_W-1:0];
          CFG_DATA_BYTES:  data_bytes  <= cfg_data[DBYTES_W-1:0];
          default: begin
          end
        endcase
      end
      if (out_set) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_TAIL;
          end
        end
        S_TAIL, S_RED: begin
          if ((state == S_TAIL) && need_red) begin
            state <= S_RED;
          end else if (commit) begin
            state <= c_peek_hit ? S_DESC : S_IDLE;
            if (c_put_ok) begin
              head_index   <= h_inc;
              write_offset <= c_woff;
            end
            if (c_tail_we) begin
              tail_valid[c_tail_waddr] <= 1'b1;
            end
            if (c_set) begin
              slot_taken[free_idx] <= 1'b1;
            end
            if (c_clr) begin
              slot_taken[rd_addr_q] <= 1'b0;
            end
            attached_count <= c_count;
          end
        end
        S_DESC: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload: request, tail store, reduction results and response fields.
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q     <= req.func;
      rd_valid_q <= (req.reader != '0) && (32'(req.reader) < 32'(READER_SLOTS));
      rd_addr_q  <= TW'(req.reader);
      meta_q     <= req.meta[META_BITS-1:0];
      len_q      <= req.length & LEN_MASK;
      h_q        <= head_index;
      tail_q     <= tail_mem[TW'(req.reader)];
      tvalid_q   <= tail_valid[TW'(req.reader)];
    end
    if ((state == S_TAIL) && need_red) begin
      t_q <= t_raw;
    end
    if (mod_start) begin
      mod_sel <= mod_pick_tail;
    end
    if ((state == S_RED) && mod_stat.done) begin
      if (mod_sel) begin
        t_q <= mod_result;
      end else begin
        h_q <= mod_result;
      end
    end
    if (commit && c_tail_we) begin
      tail_mem[c_tail_waddr] <= c_tail_wdata;
    end
    if (commit && c_peek_hit) begin
      pend_q <= c_pend;
    end
    if (commit && !c_peek_hit) begin
      o_status <= c_status;
      o_meta   <= c_meta;
      o_len    <= c_len;
      o_off    <= c_put_ok ? c_off : '0;
      o_pend   <= c_pend;
      o_slot   <= SLOT_W'(c_slot);
      o_count  <= COUNT_W'(c_count);
    end
    if ((state == S_DESC) && out_free) begin
      o_status <= ST_OK;
      o_meta   <= META_W'(d_meta);
      o_len    <= d_len;
      o_off    <= d_off;
      o_pend   <= pend_q;
      o_slot   <= '0;
      o_count  <= COUNT_W'(attached_count);
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = o_status;
  assign rsp.meta_out     = o_meta;
  assign rsp.length_out   = o_len;
  assign rsp.offset_out   = o_off;
  assign rsp.pending      = o_pend;
  assign rsp.slot_out     = o_slot;
  assign rsp.reader_count = o_count;

endmodule

// File: tb/ring_reply_checker.sv
// Watches the frame ring's channels and config port, predicts each response word and compares it.
`timescale 1ns / 100ps

module ring_reply_checker
  import rmr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  rmr_in_if                     req,
  rmr_out_if                    rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    waiting
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [META_W-1:0]   meta;
    logic [LEN_W-1:0]    length;
    logic [LEN_W-1:0]    offset;
    logic [PEND_W-1:0]   pending;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  count;
  } ring_reply_t;

  // Shadow copy of the ring state and its two registers.
  logic [FSLOT_W-1:0]  frame_slots_q;
  logic [DBYTES_W-1:0] data_bytes_q;
  logic [5:0]          head_idx;
  logic [24:0]         wr_off;
  logic [5:0]          tail_idx [0:READER_SLOTS_DEF-1];
  bit                  slot_busy [0:READER_SLOTS_DEF-1];
  logic [COUNT_W-1:0]  readers_on;
  logic [META_W-1:0]   desc_md [0:RING_DEPTH_DEF-1];
  logic [LEN_W-1:0]    desc_ln [0:RING_DEPTH_DEF-1];
  logic [LEN_W-1:0]    desc_of [0:RING_DEPTH_DEF-1];

  ring_reply_t replies_due [$];
  ring_reply_t want, got;

  function automatic ring_reply_t apply_ring_op(logic [FUNC_W-1:0] fn, logic [READER_W-1:0] rd,
                                                logic [META_W-1:0] md, logic [LEN_W-1:0] ln);
    ring_reply_t r;
    int unsigned n, h, t, off, slot;
    bit has_tail, pend_fixed;
    n = (frame_slots_q < 2) ? 2 :
        (frame_slots_q > RING_DEPTH_DEF) ? RING_DEPTH_DEF : int'(frame_slots_q);
    h = head_idx % n;
    has_tail = (rd != 0);
    pend_fixed = 0;
    slot = 0;
    r = '0;
    r.status = ST_REFUSED;
    case (fn)
      FUNC_PUT: begin
        if (readers_on == 0) begin
          r.status = ST_REFUSED;
        end else if (ln > data_bytes_q) begin
          r.status = ST_TOO_LARGE;
        end else begin
          off = wr_off;
          if (ln + off > data_bytes_q || off > 32'hFF_FFFF) off = 0;
          desc_md[h] = md;
          desc_ln[h] = ln;
          desc_of[h] = off[LEN_W-1:0];
          wr_off = 25'(off + ln);
          head_idx = 6'((h + 1) % n);
          r.status = ST_OK;
          r.meta = md;
          r.length = ln;
          r.offset = off[LEN_W-1:0];
        end
      end
      FUNC_PEEK: begin
        if (has_tail) begin
          t = tail_idx[rd] % n;
          if (t != h) begin
            r.status = ST_OK;
            r.meta = desc_md[t];
            r.length = desc_ln[t];
            r.offset = desc_of[t];
          end
        end
      end
      FUNC_ADVANCE: begin
        if (has_tail) begin
          t = tail_idx[rd] % n;
          if (t != h) begin
            tail_idx[rd] = 6'((t + 1) % n);
            r.status = ST_OK;
          end
        end
      end
      FUNC_SYNC: begin
        if (has_tail) begin
          tail_idx[rd] = 6'(h);
          r.status = ST_OK;
        end
      end
      FUNC_ATTACH: begin
        r.status = ST_NO_SLOT;
        for (int i = 1; i < READER_SLOTS_DEF; i++)
          if (slot == 0 && !slot_busy[i]) slot = i;
        if (slot != 0) begin
          slot_busy[slot] = 1;
          tail_idx[slot] = 6'(h);
          readers_on = readers_on + 1'b1;
          r.status = ST_OK;
          r.slot = slot[SLOT_W-1:0];
        end
        // a fresh tail sits on the head, so nothing is pending for it
        pend_fixed = 1;
      end
      FUNC_DETACH: begin
        if (has_tail && slot_busy[rd]) begin
          slot_busy[rd] = 0;
          if (readers_on != 0) readers_on = readers_on - 1'b1;
          r.status = ST_OK;
        end
      end
      default: ;
    endcase
    if (!pend_fixed && has_tail)
      r.pending = PEND_W'(((head_idx % n) + n - (tail_idx[rd] % n)) % n);
    r.count = readers_on;
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      frame_slots_q = FRAME_SLOTS_RST;
      data_bytes_q = DATA_BYTES_RST;
      head_idx = '0;
      wr_off = '0;
      readers_on = '0;
      for (int i = 0; i < READER_SLOTS_DEF; i++) begin
        tail_idx[i] = '0;
        slot_busy[i] = 0;
      end
      for (int i = 0; i < RING_DEPTH_DEF; i++) begin
        desc_md[i] = '0;
        desc_ln[i] = '0;
        desc_of[i] = '0;
      end
      replies_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_SLOTS: frame_slots_q = cfg_data[FSLOT_W-1:0];
          CFG_DATA_BYTES:  data_bytes_q = cfg_data[DBYTES_W-1:0];
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.status, rsp.meta_out, rsp.length_out, rsp.offset_out, rsp.pending,
                rsp.slot_out, rsp.reader_count};
        if (replies_due.size() == 0) begin
          fail_count++;
          $display("%0t: response word with none expected, actual %0h", $time, got);
        end else begin
          want = replies_due.pop_front();
          check_field("status", 64'(want.status), 64'(got.status));
          check_field("meta_out", want.meta, got.meta);
          check_field("length_out", 64'(want.length), 64'(got.length));
          check_field("offset_out", 64'(want.offset), 64'(got.offset));
          check_field("pending", 64'(want.pending), 64'(got.pending));
          check_field("slot_out", 64'(want.slot), 64'(got.slot));
          check_field("reader_count", 64'(want.count), 64'(got.count));
        end
      end
      if (req.valid && req.ready)
        replies_due.push_back(apply_ring_op(req.func, req.reader, req.meta, req.length));
    end
    waiting = replies_due.size();
  end

endmodule

// File: tb/multi_reader_frame_ring_unit_test.sv
// Stimulus and verdict for the multi-reader frame descriptor ring.
`timescale 1ns / 100ps

module multi_reader_frame_ring_unit_test;
  import rmr_pkg::*;

  // Func codes the block does not define; it must refuse them.
  localparam logic [FUNC_W-1:0]   FUNC_UNUSED_6 = 3'd6;
  localparam logic [FUNC_W-1:0]   FUNC_UNUSED_7 = 3'd7;
  localparam logic [READER_W-1:0] WRITER_SLOT   = 3'd0;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int PHASE_WORDS  = 210;
  localparam int DRAIN_CYCLES = 10;

  logic clk;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int waiting;
  int send_idle;
  int recv_idle;
  int cycles;
  logic [DBYTES_W-1:0] cur_db;
  logic [FSLOT_W-1:0]  next_fs;
  logic [DBYTES_W-1:0] next_db;

  rmr_in_if  req_if ();
  rmr_out_if rsp_if ();

  multi_reader_frame_ring_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ring_reply_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_if),
    .rsp        (rsp_if),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .waiting    (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Response side: stall at random, at the rate the current phase asks.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Hard stop if the ring hangs or a response never shows up.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Offer one request word, possibly after some idle cycles, and hold it until the
  // block takes it. Return at the falling edge after the accept, with valid still high,
  // so back-to-back words keep valid up without a glitch.
  task automatic send_word(logic [FUNC_W-1:0] fn, logic [READER_W-1:0] rd,
                           logic [META_W-1:0] md, logic [LEN_W-1:0] ln);
    while ($urandom_range(0, 99) < send_idle) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid  <= 1'b1;
    req_if.func   <= fn;
    req_if.reader <= rd;
    req_if.meta   <= md;
    req_if.length <= ln;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drain the ring, then write both registers while it is idle. A new slot count
  // can leave old tails pointing at never-written descriptors, so rewind every
  // reader tail to the head before anything can peek.
  task automatic write_config(logic [FSLOT_W-1:0] fs, logic [DBYTES_W-1:0] db);
    req_if.valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FRAME_SLOTS;
    cfg_data  <= CFG_DATA_W'(fs);
    @(negedge clk);
    cfg_index <= CFG_DATA_BYTES;
    cfg_data  <= db;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_db = db;
    for (int r = 1; r < READER_SLOTS_DEF; r++)
      send_word(FUNC_SYNC, READER_W'(r), {$urandom, $urandom}, 24'($urandom));
  endtask

  // One random request word. Puts dominate so the readers have frames to chase;
  // lengths are mostly short, some full width, some hugging the data area size.
  task automatic random_op();
    int pick, v;
    logic [FUNC_W-1:0]   fn;
    logic [READER_W-1:0] rd;
    logic [LEN_W-1:0]    ln;
    pick = $urandom_range(0, 99);
    if (pick < 36)      fn = FUNC_PUT;
    else if (pick < 54) fn = FUNC_PEEK;
    else if (pick < 72) fn = FUNC_ADVANCE;
    else if (pick < 78) fn = FUNC_SYNC;
    else if (pick < 87) fn = FUNC_ATTACH;
    else if (pick < 97) fn = FUNC_DETACH;
    else                fn = $urandom_range(0, 1) ? FUNC_UNUSED_6 : FUNC_UNUSED_7;
    rd = ($urandom_range(0, 9) == 0) ? WRITER_SLOT : READER_W'($urandom_range(1, 7));
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      ln = LEN_W'($urandom_range(0, 255));
    end else if (pick < 75) begin
      ln = LEN_W'($urandom);
    end else begin
      v = int'(cur_db) + int'($urandom_range(0, 4)) - 2;
      if (v < 0) v = 0;
      if (v > 32'hFF_FFFF) v = 32'hFF_FFFF;
      ln = LEN_W'(v);
    end
    send_word(fn, rd, {$urandom, $urandom}, ln);
  endtask

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = CFG_FRAME_SLOTS;
    cfg_data     = '0;
    req_if.valid = 1'b0;
    req_if.func  = FUNC_PUT;
    req_if.reader = WRITER_SLOT;
    req_if.meta  = '0;
    req_if.length = '0;
    send_idle    = 15;
    recv_idle    = 83;
    cur_db       = DATA_BYTES_RST;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, on reset register values. A put with nobody attached is refused.
    send_word(FUNC_PUT, WRITER_SLOT, '1, 24'hFF_FFFF);
    // The writer slot has no tail: peek, advance, sync and detach all refuse.
    send_word(FUNC_PEEK, WRITER_SLOT, '0, '0);
    send_word(FUNC_ADVANCE, WRITER_SLOT, '0, '0);
    send_word(FUNC_SYNC, WRITER_SLOT, '0, '0);
    send_word(FUNC_DETACH, WRITER_SLOT, '0, '0);
    // Detach of a slot nobody holds, then the two undefined func codes.
    send_word(FUNC_DETACH, 3'd5, '0, '0);
    send_word(FUNC_UNUSED_6, 3'd7, '1, 24'hFF_FFFF);
    send_word(FUNC_UNUSED_7, 3'd2, 64'h5555_5555_5555_5555, 24'h55_5555);
    send_word(FUNC_ATTACH, 3'd3, '0, '0);
    // Empty ring: peek and advance report empty.
    send_word(FUNC_PEEK, 3'd1, '0, '0);
    send_word(FUNC_ADVANCE, 3'd1, '0, '0);
    // Push the write offset to exactly 2^24, so the next frame's offset no
    // longer fits in the offset field and wraps to zero.
    send_word(FUNC_PUT, 3'd1, 64'hAAAA_AAAA_AAAA_AAAA, 24'hFF_FFFF);
    send_word(FUNC_PUT, 3'd6, '1, 24'd1);
    send_word(FUNC_PUT, 3'd1, '0, 24'd0);
    send_word(FUNC_PEEK, 3'd1, '0, '0);
    send_word(FUNC_ADVANCE, 3'd1, '0, '0);
    // Reader 2 is not attached but still has a tail that peek and sync act on.
    send_word(FUNC_PEEK, 3'd2, '0, '0);
    send_word(FUNC_SYNC, 3'd2, '0, '0);

    // Small ring and small data area: oversized frame, offset wrap at the end of
    // the data area, and the writer lapping reader 1 in a ring of three.
    write_config(7'd3, 25'd100);
    send_word(FUNC_PUT, 3'd1, {$urandom, $urandom}, 24'd101);
    send_word(FUNC_PUT, 3'd1, {$urandom, $urandom}, 24'd60);
    send_word(FUNC_PUT, 3'd1, {$urandom, $urandom}, 24'd60);
    send_word(FUNC_PUT, 3'd1, {$urandom, $urandom}, 24'd40);
    send_word(FUNC_PUT, 3'd1, {$urandom, $urandom}, 24'd0);
    send_word(FUNC_PEEK, 3'd1, '0, '0);
    send_word(FUNC_DETACH, 3'd1, '0, '0);

    // Random phases. Register settings run through the extremes: counts below 2
    // and above the ring depth, a data area of zero and of 2^25-1.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin next_fs = 7'd64;  next_db = 25'd16777216; end
        1: begin next_fs = 7'd2;   next_db = 25'd1;        end
        2: begin next_fs = 7'd127; next_db = 25'h1FF_FFFF; end
        3: begin next_fs = 7'd0;   next_db = 25'd0;        end
        4: begin
          next_fs = FSLOT_W'($urandom_range(3, 63));
          next_db = DBYTES_W'($urandom_range(1000, 1 << 20));
        end
        default: begin
          next_fs = 7'd1;
          next_db = DBYTES_W'($urandom_range(1, 32'h1FF_FFFF));
        end
      endcase
      // Sender mostly busy first, then receiver mostly busy, then no idling.
      send_idle = (ph < 2) ? 15 : (ph < 4) ? 83 : 0;
      recv_idle = (ph < 2) ? 83 : (ph < 4) ? 15 : 0;
      write_config(next_fs, next_db);
      repeat (PHASE_WORDS) random_op();
    end

    // Drop valid, wait for every response, then give stray words time to show.
    req_if.valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
